// ===== hw/rtl/mis_pkg.sv =====
// Shared constants and types for the merge insertion sorter.
`default_nettype none
package mis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 31;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mis_cell.sv =====
// One storage cell of the sorting chain: insert with right shift, drain with left shift.
`default_nettype none
module mis_cell
  import mis_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire value_t    new_value,
  input  wire logic      occ,
  input  wire logic      tail,
  input  wire value_t    prev_value,
  input  wire logic      prev_gt,
  input  wire value_t    next_value,
  output value_t         value,
  output logic           gt
);

  value_t value_r;
  value_t value_nxt;

  assign value = value_r;
  assign gt    = occ && (value_r > new_value);

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (gt || tail) begin
        value_nxt = prev_gt ? prev_value : new_value;
      end
    end else if (ctl.shift) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/merge_insertion_sorter.sv =====
// Batch sorter top level: a chain of cells kept in ascending order, drained after the last item.
// Load: one input transfer per cycle while in the load state, each value inserted in place as it is taken.
// Drain: first result is offered the cycle after the closing transfer, then one per cycle while out_ready is high.
// Input is stalled while a batch drains.
// Reset (synchronous, rst_n low) clears the fill count, overflow flag and state;
// cell contents are not reset and are only read below the fill count.
`default_nettype none
module merge_insertion_sorter
  import mis_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire value_t in_value,
  input  wire logic   in_last,
  output logic        out_valid,
  input  wire logic   out_ready,
  output value_t      out_sorted_value,
  output logic        out_last_res,
  output logic        out_overflow
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic   state_r, state_nxt;
  count_t cnt_r, cnt_nxt;
  logic   dropped_r, dropped_nxt;

  logic      in_xfer, out_xfer, has_room;
  cell_ctl_t ctl;

  value_t vals [MAX_ITEMS];
  logic   gts  [MAX_ITEMS];

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_DRAIN);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign has_room  = (cnt_r < count_t'(MAX_ITEMS));

  assign ctl.ins   = in_xfer && has_room;
  assign ctl.shift = out_xfer;

  assign out_sorted_value = vals[0];
  assign out_last_res     = (cnt_r == count_t'(1));
  assign out_overflow     = out_last_res && dropped_r;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    value_t prev_v, next_v;
    logic   prev_g;

    if (i == 0) begin : g_head
      assign prev_v = '0;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_v = vals[i-1];
      assign prev_g = gts[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign next_v = vals[i];
    end else begin : g_mid
      assign next_v = vals[i+1];
    end

    mis_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_value  (in_value),
      .occ        (count_t'(i) < cnt_r),
      .tail       (count_t'(i) == cnt_r),
      .prev_value (prev_v),
      .prev_gt    (prev_g),
      .next_value (next_v),
      .value      (vals[i]),
      .gt         (gts[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (has_room) begin
            cnt_nxt = cnt_r + count_t'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          cnt_nxt = cnt_r - count_t'(1);
          if (out_last_res) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= count_t'(MAX_ITEMS))
    else $error("fill count above capacity");

  a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last) |=> (out_valid && cnt_r != '0))
    else $error("closing transfer did not start a non-empty drain");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_res) |=> (cnt_r == '0 && !dropped_r && in_ready))
    else $error("batch end did not clear state");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r > count_t'(1)) |-> (vals[0] <= vals[1]))
    else $error("chain head out of order");

endmodule
`default_nettype wire

// ===== tb/tb_merge_insertion_sorter.sv =====
// Self-checking testbench for merge_insertion_sorter: directed and random batches.
module tb_merge_insertion_sorter;
  import mis_pkg::*;

  typedef struct packed {
    value_t value;
    logic   last_res;
    logic   overflow;
  } sorted_res_t;

  typedef struct packed {
    value_t      value;
    logic        is_end;
    logic        typed;
    sorted_res_t want;
  } stim_row_t;

  localparam value_t VMAX       = '1;
  localparam int     N_DIR      = 12;
  localparam int     LONG_HOLD  = 400;
  localparam int     LIMIT      = 200000;
  localparam int     RAND_ITEMS = 110;
  localparam int     CALM_FROM  = 85;
  localparam int     TAIL_CYC   = 20;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  value_t in_value  = '0;
  logic   in_last   = 1'b0;
  logic   out_ready = 1'b0;
  logic   in_ready;
  logic   out_valid;
  value_t out_sorted_value;
  logic   out_last_res;
  logic   out_overflow;

  value_t      batch_vals[$];
  bit          batch_dropped = 1'b0;
  sorted_res_t pending_sorted[$];
  int          errors = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  bit          long_hold_pending = 1'b0;

  // single-item batches with values at the field extremes are typed in
  stim_row_t dir_tab [N_DIR] = '{
    '{31'd0,          1'b1, 1'b1, '{31'd0, 1'b1, 1'b0}},
    '{VMAX,           1'b1, 1'b1, '{VMAX,  1'b1, 1'b0}},
    '{31'd5,          1'b0, 1'b0, '0},
    '{VMAX,           1'b0, 1'b0, '0},
    '{31'd0,          1'b0, 1'b0, '0},
    '{31'd5,          1'b0, 1'b0, '0},
    '{31'd3,          1'b1, 1'b0, '0},
    '{31'h2AAAAAAA,   1'b0, 1'b0, '0},
    '{31'h55555555,   1'b1, 1'b0, '0},
    '{31'd7,          1'b0, 1'b0, '0},
    '{31'd7,          1'b0, 1'b0, '0},
    '{31'd7,          1'b1, 1'b0, '0}
  };

  merge_insertion_sorter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_res     (out_last_res),
    .out_overflow     (out_overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void sort_batch_accept(input value_t v, input logic is_end,
                                            ref sorted_res_t res[$]);
    int          pos;
    sorted_res_t r;
    res = {};
    if (batch_vals.size() < MAX_ITEMS) begin
      pos = 0;
      while (pos < batch_vals.size() && batch_vals[pos] <= v) pos++;
      batch_vals.insert(pos, v);
    end else begin
      batch_dropped = 1'b1;
    end
    if (is_end) begin
      foreach (batch_vals[k]) begin
        r = '{batch_vals[k], k == batch_vals.size() - 1,
              (k == batch_vals.size() - 1) && batch_dropped};
        res = {res, r};
      end
      batch_vals.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  task automatic send_item(input value_t v, input logic is_end, input logic typed,
                           input sorted_res_t want);
    sorted_res_t fresh[$];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= is_end;
    do @(posedge clk); while (!in_ready);
    sort_batch_accept(v, is_end, fresh);
    if (typed) pending_sorted = {pending_sorted, want};
    else pending_sorted = {pending_sorted, fresh};
  endtask

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : chk_out
    sorted_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected transfer: sorted_value %0h", out_sorted_value);
        errors++;
      end else begin
        want = pending_sorted.pop_front();
        if (out_sorted_value !== want.value) begin
          $error("sorted_value: expected %0h, got %0h", want.value, out_sorted_value);
          errors++;
        end
        if (out_last_res !== want.last_res) begin
          $error("last_res: expected %0b, got %0b", want.last_res, out_last_res);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_merge_insertion_sorter: FAIL");
      $finish;
    end
  end

  initial begin
    int     n_rand;
    int     bsize;
    value_t v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].value, dir_tab[i].is_end, dir_tab[i].typed, dir_tab[i].want);
    end

    // full store, closing item dropped; receiver held so the input backs up
    for (int i = 0; i <= MAX_ITEMS; i++) begin
      send_item(value_t'(1000 - i), i == MAX_ITEMS, 1'b0, '0);
      if (i == 0) long_hold_pending = 1'b1;
    end
    // exactly full, no drop
    for (int i = 0; i < MAX_ITEMS; i++) begin
      send_item(value_t'($urandom()), i == MAX_ITEMS - 1, 1'b0, '0);
    end

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      bsize = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int j = 0; j < bsize; j++) begin
        case ($urandom_range(0, 2))
          0:       v = value_t'($urandom());
          1:       v = value_t'($urandom_range(0, 15));
          default: v = $urandom_range(0, 1) ? VMAX : value_t'(0);
        endcase
        if (n_rand >= CALM_FROM) idle_on = 1'b0;
        send_item(v, j == bsize - 1, 1'b0, '0);
        n_rand++;
      end
    end
    in_valid <= 1'b0;

    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("tb_merge_insertion_sorter: PASS");
    end else begin
      $display("tb_merge_insertion_sorter: FAIL");
    end
    $finish;
  end

endmodule
